// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== sv/sc2a_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan code to ASCII package
// Word types, scan code constants, the key map and shared parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package sc2a_pkg;

  localparam int DEF_FIFO_DEPTH = 16;
  localparam int DEF_MAX_READ   = 16;
  localparam int RESULT_CAP     = 16;
  localparam int AMOUNT_W       = 5;
  localparam int TABLE_LEN      = 58;

  localparam logic [7:0] SC_ESC       = 8'h01;
  localparam logic [7:0] SC_CTRL      = 8'h1D;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_ALT       = 8'h38;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_LSHIFT_BR = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BR = 8'hB6;
  localparam logic [7:0] SC_ALT_BR    = 8'hB8;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                op;
    logic [7:0]          scan_code;
    logic [AMOUNT_W-1:0] read_amount;
  } in_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] character;
    logic       last;
    logic       overflow;
  } out_t;

  typedef enum logic {
    CMD_KEY,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                has_char;
    logic [7:0]          ch;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_t;

  // Returns {unshifted, shifted} for a table index.
  function automatic logic [15:0] key_pair(input logic [5:0] idx);
    logic [15:0] p;
    case (idx)
      6'd1:    p = {8'd27, 8'd27};
      6'd2:    p = {"1", "!"};
      6'd3:    p = {"2", "@"};
      6'd4:    p = {"3", "#"};
      6'd5:    p = {"4", "$"};
      6'd6:    p = {"5", "%"};
      6'd7:    p = {"6", "^"};
      6'd8:    p = {"7", "&"};
      6'd9:    p = {"8", "*"};
      6'd10:   p = {"9", "("};
      6'd11:   p = {"0", ")"};
      6'd12:   p = {"-", "_"};
      6'd13:   p = {"=", "+"};
      6'd14:   p = {8'd8, 8'd8};
      6'd15:   p = {8'd9, 8'd9};
      6'd16:   p = {"q", "Q"};
      6'd17:   p = {"w", "W"};
      6'd18:   p = {"e", "E"};
      6'd19:   p = {"r", "R"};
      6'd20:   p = {"t", "T"};
      6'd21:   p = {"y", "Y"};
      6'd22:   p = {"u", "U"};
      6'd23:   p = {"i", "I"};
      6'd24:   p = {"o", "O"};
      6'd25:   p = {"p", "P"};
      6'd26:   p = {"[", "{"};
      6'd27:   p = {"]", "}"};
      6'd28:   p = {8'd10, 8'd10};
      6'd30:   p = {"a", "A"};
      6'd31:   p = {"s", "S"};
      6'd32:   p = {"d", "D"};
      6'd33:   p = {"f", "F"};
      6'd34:   p = {"g", "G"};
      6'd35:   p = {"h", "H"};
      6'd36:   p = {"j", "J"};
      6'd37:   p = {"k", "K"};
      6'd38:   p = {"l", "L"};
      6'd39:   p = {";", ":"};
      6'd40:   p = {8'h27, 8'h22};
      6'd41:   p = {8'd167, "~"};
      6'd43:   p = {8'h5C, "|"};
      6'd44:   p = {"z", "Z"};
      6'd45:   p = {"x", "X"};
      6'd46:   p = {"c", "C"};
      6'd47:   p = {"v", "V"};
      6'd48:   p = {"b", "B"};
      6'd49:   p = {"n", "N"};
      6'd50:   p = {"m", "M"};
      6'd51:   p = {",", "<"};
      6'd52:   p = {".", ">"};
      6'd53:   p = {"/", "?"};
      6'd57:   p = {" ", " "};
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sc2a_front.sv =====
// ----------------------------------------------------------------------------
// Scan code front end
// Accepts input words, tracks shift and caps lock, and turns each word into
// a key or read command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_front #(
  parameter int MAX_READ = sc2a_pkg::DEF_MAX_READ
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire sc2a_pkg::in_t  in_word,
  output logic                full,
  output logic                cmd_push,
  output sc2a_pkg::cmd_t      cmd,
  input  wire logic           cmd_full
);
  import sc2a_pkg::*;

  localparam int CAP = (MAX_READ < RESULT_CAP) ? MAX_READ : RESULT_CAP;
  localparam logic [AMOUNT_W-1:0] CAP_AMOUNT = AMOUNT_W'(CAP);

  logic        shift_held;
  logic        shift_held_next;
  logic        caps_on;
  logic        caps_on_next;
  logic        accept;
  logic [15:0] pair;
  logic [7:0]  ch;

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign cmd_push = accept;
  assign pair     = key_pair(in_word.scan_code[5:0]);
  assign ch       = (shift_held || caps_on) ? pair[7:0] : pair[15:8];

  always_comb begin
    shift_held_next = shift_held;
    caps_on_next    = caps_on;
    cmd.kind        = CMD_KEY;
    cmd.has_char    = 1'b0;
    cmd.ch          = ch;
    cmd.amount      = (in_word.read_amount > CAP_AMOUNT) ? CAP_AMOUNT : in_word.read_amount;
    if (in_word.op == OP_READ) begin
      cmd.kind = CMD_READ;
    end else if (in_word.scan_code inside {SC_LSHIFT, SC_RSHIFT}) begin
      shift_held_next = 1'b1;
    end else if (in_word.scan_code inside {SC_LSHIFT_BR, SC_RSHIFT_BR}) begin
      shift_held_next = 1'b0;
    end else if (in_word.scan_code == SC_CAPS) begin
      caps_on_next = !caps_on;
    end else if (in_word.scan_code inside {SC_ESC, SC_CTRL, SC_ALT, SC_ALT_BR}) begin
      cmd.has_char = 1'b0;
    end else if (in_word.scan_code < 8'(TABLE_LEN)) begin
      cmd.has_char = (ch != 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
    end else if (accept) begin
      shift_held <= shift_held_next;
      caps_on    <= caps_on_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sc2a_cmdq.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2a_cmdq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sc2a_pkg::cmd_t  push_cmd,
  output logic                 full,
  output logic                 valid,
  output sc2a_pkg::cmd_t       head,
  input  wire logic            pop
);
  import sc2a_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign head    = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sc2a_back.sv =====
// ----------------------------------------------------------------------------
// Character FIFO back end
// Executes key and read commands against the character store and drives
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sc2a_back #(
  parameter int FIFO_DEPTH = sc2a_pkg::DEF_FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire sc2a_pkg::cmd_t  cmd,
  output logic                 cmd_pop,
  output logic                 empty,
  input  wire logic            pop,
  output sc2a_pkg::out_t       out_word
);
  import sc2a_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int MW = (CW > AMOUNT_W) ? CW : AMOUNT_W;
  localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(FIFO_DEPTH);

  logic [7:0]          mem [FIFO_DEPTH];
  logic [7:0]          rd_data;
  logic [PW-1:0]       rd_addr;
  logic [PW-1:0]       write_ptr;
  logic [PW-1:0]       read_ptr;
  logic [PW-1:0]       read_ptr_inc;
  logic [CW-1:0]       fill_count;
  logic [AMOUNT_W-1:0] remain;
  logic [AMOUNT_W-1:0] take;
  back_state_t         state;
  back_state_t         state_next;
  out_t                res;
  logic                res_valid;
  logic                out_free;
  logic                emit;
  out_t                emit_word;
  logic                mem_we;
  logic                rd_step;
  logic                load_remain;

  assign out_free     = !res_valid || pop;
  assign empty        = !res_valid;
  assign out_word     = res;
  assign read_ptr_inc = (read_ptr == LAST_PTR) ? '0 : read_ptr + PW'(1);
  assign rd_addr      = rd_step ? read_ptr_inc : read_ptr;
  assign take         = (MW'(fill_count) < MW'(cmd.amount)) ? AMOUNT_W'(fill_count)
                                                            : cmd.amount;

  always_comb begin
    cmd_pop     = 1'b0;
    emit        = 1'b0;
    emit_word   = '{char_valid: 1'b0, character: 8'h00, last: 1'b1, overflow: 1'b0};
    mem_we      = 1'b0;
    rd_step     = 1'b0;
    load_remain = 1'b0;
    case (state)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_KEY) begin
            emit               = 1'b1;
            emit_word.overflow = cmd.has_char && (fill_count == DEPTH_CNT);
            mem_we             = cmd.has_char && (fill_count != DEPTH_CNT);
          end else if (take == '0) begin
            emit = 1'b1;
          end else begin
            load_remain = 1'b1;
          end
        end
      end
      B_READ: begin
        if (out_free) begin
          emit                 = 1'b1;
          rd_step              = 1'b1;
          emit_word.char_valid = 1'b1;
          emit_word.character  = rd_data;
          emit_word.last       = (remain == AMOUNT_W'(1));
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (load_remain) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        if (rd_step && remain == AMOUNT_W'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_ptr] <= cmd.ch;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      res_valid  <= 1'b0;
      write_ptr  <= '0;
      read_ptr   <= '0;
      fill_count <= '0;
      remain     <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      if (mem_we) begin
        write_ptr  <= (write_ptr == LAST_PTR) ? '0 : write_ptr + PW'(1);
        fill_count <= fill_count + CW'(1);
      end else if (rd_step) begin
        fill_count <= fill_count - CW'(1);
      end
      if (rd_step) begin
        read_ptr <= read_ptr_inc;
        remain   <= remain - AMOUNT_W'(1);
      end else if (load_remain) begin
        remain <= take;
      end
    end
  end

  `ASSERT_PROP(a_fill_bound, clk, rst, fill_count <= DEPTH_CNT, "fill count above depth")
  `ASSERT_PROP(a_read_covered, clk, rst, (state == B_READ) |-> (remain != '0 && MW'(fill_count) >= MW'(remain)), "read count exceeds stored characters")
  `ASSERT_NEVER(a_no_write_in_read, clk, rst, mem_we && state == B_READ, "store written during a read")
  `ASSERT_PROP(a_read_emits_char, clk, rst, (state == B_READ && out_free) |=> (res_valid && res.char_valid), "read step gave no character")

endmodule

`default_nettype wire

// ===== sv/scan_code_to_ascii_fifo_top.sv =====
// ----------------------------------------------------------------------------
// Scan code to ASCII with character FIFO
// A key word or an empty read passes through the command queue and then the
// result register; a read that returns characters first loads its count.
// Throughput: one key word per cycle while results are taken and no read runs;
// after its load step, a read does one store read per cycle while results flow.
// Reset clears shift, caps lock, the pointers, the fill count and both queues;
// the character store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_code_to_ascii_fifo_top #(
  parameter int FIFO_DEPTH = sc2a_pkg::DEF_FIFO_DEPTH,
  parameter int MAX_READ   = sc2a_pkg::DEF_MAX_READ
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire sc2a_pkg::in_t  in_word,
  output logic                empty,
  input  wire logic           pop,
  output sc2a_pkg::out_t      out_word
);
  import sc2a_pkg::*;

  cmd_t front_cmd;
  logic front_push;
  logic q_full;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  sc2a_front #(
    .MAX_READ(MAX_READ)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_word  (in_word),
    .full     (full),
    .cmd_push (front_push),
    .cmd      (front_cmd),
    .cmd_full (q_full)
  );

  sc2a_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  sc2a_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Scan code to ASCII FIFO testbench
// Drives scan code and read words through the push/full side and checks each
// result word on the empty/pop side against a keyboard map and character
// queue kept here. A short table of directed words comes first, then random
// words under several idle and stall patterns, including one long stall of
// the receiver that backs the block up until it refuses input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sc2a_pkg::*;

  localparam int FIFO_DEPTH  = DEF_FIFO_DEPTH;
  localparam int READ_CAP    = (DEF_MAX_READ < RESULT_CAP) ? DEF_MAX_READ : RESULT_CAP;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SCRIPT_LEN  = 26;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam out_t QUIET = '{char_valid: 1'b0, character: 8'h00, last: 1'b1, overflow: 1'b0};

  localparam logic [0:TABLE_LEN-1][7:0] KEY_PLAIN = {
    8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8, 8'd9,
    "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10, 8'd0,
    "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'd167, 8'd0, 8'h5C,
    "z", "x", "c", "v", "b", "n", "m", ",", ".", "/",
    8'd0, 8'd0, 8'd0, " "
  };

  localparam logic [0:TABLE_LEN-1][7:0] KEY_SHIFTED = {
    8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8, 8'd9,
    "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10, 8'd0,
    "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'd0, "|",
    "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?",
    8'd0, 8'd0, 8'd0, " "
  };

  typedef struct packed {
    in_t  word;
    logic typed;
    out_t exp;
  } script_row_t;

  typedef struct packed {
    logic typed;
    out_t exp;
  } word_note_t;

  localparam script_row_t [0:SCRIPT_LEN-1] SCRIPT = {
    {OP_READ, 8'h00,        5'd1,  TYPED,     QUIET},
    {OP_READ, 8'hFF,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h00,        5'd31, TYPED,     QUIET},
    {OP_KEY,  SC_ESC,       5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_CTRL,      5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h02,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_LSHIFT,    5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h02,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_LSHIFT_BR, 5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_RSHIFT,    5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h39,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_RSHIFT_BR, 5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_CAPS,      5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h1E,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h29,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_CAPS,      5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h29,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h2B,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_ALT,       5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h10,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  SC_ALT_BR,    5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h37,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'h7F,        5'd0,  TYPED,     QUIET},
    {OP_KEY,  8'hFF,        5'd0,  TYPED,     QUIET},
    {OP_READ, 8'h00,        5'd31, PREDICTED, QUIET},
    {OP_READ, 8'h00,        5'd1,  TYPED,     QUIET}
  };

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t  in_word = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_word;

  int send_idle = 0;
  int recv_stall = 0;
  logic hold_armed = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;

  out_t       due[$];
  word_note_t notes[$];

  logic       shift_down;
  logic       caps_lock;
  logic       alt_down;
  logic [7:0] held_chars [FIFO_DEPTH];
  int         wr_idx;
  int         rd_idx;
  int         held_count;

  scan_code_to_ascii_fifo_top dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic decode_and_queue(input in_t w);
    out_t       r;
    logic [7:0] ch;
    int         amt;
    int         n;
    if (w.op == OP_KEY) begin
      r = QUIET;
      case (w.scan_code)
        SC_ESC, SC_CTRL: ;
        SC_LSHIFT, SC_RSHIFT: shift_down = 1'b1;
        SC_LSHIFT_BR, SC_RSHIFT_BR: shift_down = 1'b0;
        SC_CAPS: caps_lock = !caps_lock;
        SC_ALT: alt_down = 1'b1;
        SC_ALT_BR: alt_down = 1'b0;
        default: begin
          if (w.scan_code < TABLE_LEN) begin
            ch = (shift_down || caps_lock) ? KEY_SHIFTED[w.scan_code[5:0]]
                                           : KEY_PLAIN[w.scan_code[5:0]];
            if (ch != 8'd0) begin
              if (held_count >= FIFO_DEPTH) begin
                r.overflow = 1'b1;
              end else begin
                held_chars[wr_idx] = ch;
                wr_idx = (wr_idx + 1) % FIFO_DEPTH;
                held_count++;
              end
            end
          end
        end
      endcase
      due.push_back(r);
    end else begin
      amt = (w.read_amount > READ_CAP) ? READ_CAP : int'(w.read_amount);
      n = (held_count < amt) ? held_count : amt;
      if (n == 0) begin
        due.push_back(QUIET);
      end
      for (int i = 0; i < n; i++) begin
        r.char_valid = 1'b1;
        r.character = held_chars[rd_idx];
        r.last = (i == n - 1);
        r.overflow = 1'b0;
        due.push_back(r);
        rd_idx = (rd_idx + 1) % FIFO_DEPTH;
        held_count--;
      end
    end
  endtask

  function automatic in_t random_word(input int read_pct);
    in_t w;
    int  pick;
    w.op = OP_KEY;
    w.scan_code = 8'($urandom_range(255));
    w.read_amount = 5'($urandom_range(31));
    if ($urandom_range(99) < read_pct) begin
      w.op = OP_READ;
      if ($urandom_range(9) != 0) begin
        w.read_amount = 5'($urandom_range(16, 1));
      end
    end else begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        w.scan_code = 8'($urandom_range(TABLE_LEN - 1));
      end else if (pick < 85) begin
        case ($urandom_range(8))
          0: w.scan_code = SC_ESC;
          1: w.scan_code = SC_CTRL;
          2: w.scan_code = SC_LSHIFT;
          3: w.scan_code = SC_LSHIFT_BR;
          4: w.scan_code = SC_RSHIFT;
          5: w.scan_code = SC_RSHIFT_BR;
          6: w.scan_code = SC_CAPS;
          7: w.scan_code = SC_ALT;
          default: w.scan_code = SC_ALT_BR;
        endcase
      end
    end
    return w;
  endfunction

  task automatic send_word(input in_t w, input logic typed, input out_t exp);
    word_note_t note;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      in_word <= random_word(50);
      @(negedge clk);
    end
    note.typed = typed;
    note.exp = exp;
    notes.push_back(note);
    push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                           input int read_pct);
    send_idle = idle_pct;
    recv_stall = stall_pct;
    for (int k = 0; k < count; k++) begin
      send_word(random_word(read_pct), PREDICTED, QUIET);
    end
  endtask

  initial begin : receiver
    int   hold_left;
    logic hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin : monitor
    word_note_t note;
    out_t       want;
    int         due_mark;
    if (rst) begin
      shift_down = 1'b0;
      caps_lock = 1'b0;
      alt_down = 1'b0;
      wr_idx = 0;
      rd_idx = 0;
      held_count = 0;
    end else begin
      if (push && !full) begin
        note = notes.pop_front();
        due_mark = due.size();
        decode_and_queue(in_word);
        if (note.typed) begin
          while (due.size() > due_mark) begin
            due.delete(due.size() - 1);
          end
          due.push_back(note.exp);
        end
      end
      if (pop && !empty) begin
        if (due.size() == 0) begin
          $display("%0t: word with none expected: valid=%0b char=%02h last=%0b ovf=%0b",
                   $time, out_word.char_valid, out_word.character, out_word.last,
                   out_word.overflow);
          mismatches++;
        end else begin
          want = due.pop_front();
          if (out_word !== want) begin
            $display("%0t: expected valid=%0b char=%02h last=%0b ovf=%0b", $time,
                     want.char_valid, want.character, want.last, want.overflow);
            $display("%0t:      got valid=%0b char=%02h last=%0b ovf=%0b", $time,
                     out_word.char_valid, out_word.character, out_word.last,
                     out_word.overflow);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int k = 0; k < SCRIPT_LEN; k++) begin
      send_word(SCRIPT[k].word, SCRIPT[k].typed, SCRIPT[k].exp);
    end
    run_phase(0, 0, 90, 25);
    run_phase(84, 0, 80, 15);
    run_phase(0, 84, 80, 30);
    hold_armed = 1'b1;
    run_phase(0, 0, 90, 20);
    run_phase(6, 6, 90, 10);
    @(negedge clk);
    push <= 1'b0;
    while (due.size() != 0 || notes.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
